// ===== rtl/core/sgi_pkg.sv =====
// Shared constants and types for the segment intersection core.
`timescale 1ns / 1ps
package sgi_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;

  // Control word that travels with each request through the pipeline.
  typedef struct packed {
    logic vld;
    logic hit;
    logic neg_x;
    logic neg_y;
  } sgi_ctl_t;

endpackage

// ===== rtl/core/sgi_req_if.sv =====
// Request channel: two segments as four signed endpoints.
`timescale 1ns / 1ps
interface sgi_req_if #(
  parameter int unsigned COORD_BITS = sgi_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_a_start_x;
  logic signed [COORD_BITS-1:0] seg_a_start_y;
  logic signed [COORD_BITS-1:0] seg_a_end_x;
  logic signed [COORD_BITS-1:0] seg_a_end_y;
  logic signed [COORD_BITS-1:0] seg_b_start_x;
  logic signed [COORD_BITS-1:0] seg_b_start_y;
  logic signed [COORD_BITS-1:0] seg_b_end_x;
  logic signed [COORD_BITS-1:0] seg_b_end_y;

  modport source (
    output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    input  ready
  );
  modport sink (
    input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    output ready
  );
endinterface

// ===== rtl/core/sgi_res_if.sv =====
// Result channel: hit flag and rounded crossing point.
`timescale 1ns / 1ps
interface sgi_res_if #(
  parameter int unsigned COORD_BITS = sgi_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic signed [COORD_BITS-1:0] cross_x;
  logic signed [COORD_BITS-1:0] cross_y;

  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

// ===== rtl/core/sgi_front.sv =====
// Front pipeline: line equations, side tests, denominator, numerators, magnitudes.
`timescale 1ns / 1ps
module sgi_front #(
  parameter int unsigned COORD_BITS = sgi_pkg::COORD_BITS_DEF,
  localparam int unsigned DW = 2 * COORD_BITS + 3,
  localparam int unsigned NW = 3 * COORD_BITS + 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  input  logic signed [COORD_BITS-1:0] x2_i,
  input  logic signed [COORD_BITS-1:0] y2_i,
  input  logic signed [COORD_BITS-1:0] x3_i,
  input  logic signed [COORD_BITS-1:0] y3_i,
  input  logic signed [COORD_BITS-1:0] x4_i,
  input  logic signed [COORD_BITS-1:0] y4_i,
  output sgi_pkg::sgi_ctl_t            ctl_o,
  output logic [DW-1:0]                div_o,
  output logic [NW:0]                  num_x_o,
  output logic [NW:0]                  num_y_o
);
  import sgi_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned AW = C + 1;
  localparam int unsigned PW = 2 * C;
  localparam int unsigned CW = 2 * C + 1;
  localparam int unsigned QW = 2 * C + 2;
  localparam int unsigned SW = 2 * C + 3;
  localparam int unsigned MW = 3 * C + 2;

  // stage valid / control
  logic s1_vld_q, s2_vld_q, s3_vld_q;
  sgi_ctl_t s4_ctl_q, s5_ctl_q, s6_ctl_q;

  // stage 1
  logic signed [C-1:0]  x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic signed [AW-1:0] a1_q, b1_q, a2_q, b2_q;
  logic signed [PW-1:0] m1_q, m2_q, m3_q, m4_q;
  // stage 2
  logic signed [AW-1:0] a1_2q, b1_2q, a2_2q, b2_2q;
  logic signed [CW-1:0] c1_q, c2_q;
  logic signed [CW-1:0] pa3_q, pb3_q, pa4_q, pb4_q, qa1_q, qb1_q, qa2_q, qb2_q;
  logic signed [QW-1:0] dp1_q, dp2_q;
  // stage 3
  logic signed [SW-1:0] s13_q, s14_q, s21_q, s22_q, den_q;
  logic signed [MW-1:0] nx1_q, nx2_q, ny1_q, ny2_q;
  // stage 4
  logic signed [SW-1:0] den4_q;
  logic signed [NW-1:0] nx_q, ny_q;
  // stage 5
  logic [DW-1:0] ad_q;
  logic [NW-1:0] ax_q, ay_q;
  // stage 6
  logic [DW-1:0] d6_q;
  logic [NW:0]   nx6_q, ny6_q;

  logic ss1, ss2, hit4;

  // strictly on the same side: both nonzero with equal signs
  assign ss1 = (s13_q != '0) && (s14_q != '0) && (s13_q[SW-1] == s14_q[SW-1]);
  assign ss2 = (s21_q != '0) && (s22_q != '0) && (s21_q[SW-1] == s22_q[SW-1]);
  assign hit4 = !ss1 && !ss2 && (den_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_ctl_q <= '0;
      s5_ctl_q <= '0;
      s6_ctl_q <= '0;
    end else if (en_i) begin
      s1_vld_q       <= valid_i;
      s2_vld_q       <= s1_vld_q;
      s3_vld_q       <= s2_vld_q;
      s4_ctl_q.vld   <= s3_vld_q;
      s4_ctl_q.hit   <= hit4;
      s4_ctl_q.neg_x <= 1'b0;
      s4_ctl_q.neg_y <= 1'b0;
      s5_ctl_q.vld   <= s4_ctl_q.vld;
      s5_ctl_q.hit   <= s4_ctl_q.hit;
      s5_ctl_q.neg_x <= nx_q[NW-1] ^ den4_q[SW-1];
      s5_ctl_q.neg_y <= ny_q[NW-1] ^ den4_q[SW-1];
      s6_ctl_q       <= s5_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: coefficients and cross products of the endpoints
      x1_q <= x1_i; y1_q <= y1_i; x2_q <= x2_i; y2_q <= y2_i;
      x3_q <= x3_i; y3_q <= y3_i; x4_q <= x4_i; y4_q <= y4_i;
      a1_q <= AW'(y2_i) - AW'(y1_i);
      b1_q <= AW'(x1_i) - AW'(x2_i);
      a2_q <= AW'(y4_i) - AW'(y3_i);
      b2_q <= AW'(x3_i) - AW'(x4_i);
      m1_q <= PW'(x2_i) * PW'(y1_i);
      m2_q <= PW'(x1_i) * PW'(y2_i);
      m3_q <= PW'(x4_i) * PW'(y3_i);
      m4_q <= PW'(x3_i) * PW'(y4_i);
      // stage 2
      a1_2q <= a1_q; b1_2q <= b1_q; a2_2q <= a2_q; b2_2q <= b2_q;
      c1_q  <= CW'(m1_q) - CW'(m2_q);
      c2_q  <= CW'(m3_q) - CW'(m4_q);
      pa3_q <= CW'(a1_q) * CW'(x3_q);
      pb3_q <= CW'(b1_q) * CW'(y3_q);
      pa4_q <= CW'(a1_q) * CW'(x4_q);
      pb4_q <= CW'(b1_q) * CW'(y4_q);
      qa1_q <= CW'(a2_q) * CW'(x1_q);
      qb1_q <= CW'(b2_q) * CW'(y1_q);
      qa2_q <= CW'(a2_q) * CW'(x2_q);
      qb2_q <= CW'(b2_q) * CW'(y2_q);
      dp1_q <= QW'(a1_q) * QW'(b2_q);
      dp2_q <= QW'(a2_q) * QW'(b1_q);
      // stage 3: side values, denominator, numerator products
      s13_q <= SW'(pa3_q) + SW'(pb3_q) + SW'(c1_q);
      s14_q <= SW'(pa4_q) + SW'(pb4_q) + SW'(c1_q);
      s21_q <= SW'(qa1_q) + SW'(qb1_q) + SW'(c2_q);
      s22_q <= SW'(qa2_q) + SW'(qb2_q) + SW'(c2_q);
      den_q <= SW'(dp1_q) - SW'(dp2_q);
      nx1_q <= MW'(b1_2q) * MW'(c2_q);
      nx2_q <= MW'(b2_2q) * MW'(c1_q);
      ny1_q <= MW'(a2_2q) * MW'(c1_q);
      ny2_q <= MW'(a1_2q) * MW'(c2_q);
      // stage 4
      den4_q <= den_q;
      nx_q   <= NW'(nx1_q) - NW'(nx2_q);
      ny_q   <= NW'(ny1_q) - NW'(ny2_q);
      // stage 5: magnitudes
      ad_q <= den4_q[SW-1] ? DW'(-den4_q) : DW'(den4_q);
      ax_q <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
      ay_q <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
      // stage 6: add half the divisor for rounding
      d6_q  <= ad_q;
      nx6_q <= (NW+1)'(ax_q) + (NW+1)'(ad_q >> 1);
      ny6_q <= (NW+1)'(ay_q) + (NW+1)'(ad_q >> 1);
    end
  end

  assign ctl_o   = s6_ctl_q;
  assign div_o   = d6_q;
  assign num_x_o = nx6_q;
  assign num_y_o = ny6_q;

endmodule

// ===== rtl/core/sgi_div_cell.sv =====
// One restoring-division cell: one quotient bit for x and for y per stage.
`timescale 1ns / 1ps
module sgi_div_cell #(
  parameter int unsigned COORD_BITS = sgi_pkg::COORD_BITS_DEF,
  localparam int unsigned DW = 2 * COORD_BITS + 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  sgi_pkg::sgi_ctl_t     ctl_i,
  input  logic [DW-1:0]         div_i,
  input  logic [DW-1:0]         rem_x_i,
  input  logic [DW-1:0]         rem_y_i,
  input  logic [COORD_BITS-1:0] nlo_x_i,
  input  logic [COORD_BITS-1:0] nlo_y_i,
  input  logic [COORD_BITS-1:0] q_x_i,
  input  logic [COORD_BITS-1:0] q_y_i,
  output sgi_pkg::sgi_ctl_t     ctl_o,
  output logic [DW-1:0]         div_o,
  output logic [DW-1:0]         rem_x_o,
  output logic [DW-1:0]         rem_y_o,
  output logic [COORD_BITS-1:0] nlo_x_o,
  output logic [COORD_BITS-1:0] nlo_y_o,
  output logic [COORD_BITS-1:0] q_x_o,
  output logic [COORD_BITS-1:0] q_y_o
);
  import sgi_pkg::*;

  localparam int unsigned C = COORD_BITS;

  sgi_ctl_t      ctl_q;
  logic [DW-1:0] div_q, rem_x_q, rem_y_q;
  logic [C-1:0]  nlo_x_q, nlo_y_q, q_x_q, q_y_q;

  logic [DW:0] tx, ty, dx, dy;
  logic        gx, gy;

  always_comb begin
    tx = {rem_x_i, nlo_x_i[C-1]};
    ty = {rem_y_i, nlo_y_i[C-1]};
    dx = tx - {1'b0, div_i};
    dy = ty - {1'b0, div_i};
    gx = tx >= {1'b0, div_i};
    gy = ty >= {1'b0, div_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q   <= div_i;
      rem_x_q <= gx ? dx[DW-1:0] : tx[DW-1:0];
      rem_y_q <= gy ? dy[DW-1:0] : ty[DW-1:0];
      nlo_x_q <= nlo_x_i << 1;
      nlo_y_q <= nlo_y_i << 1;
      q_x_q   <= {q_x_i[C-2:0], gx};
      q_y_q   <= {q_y_i[C-2:0], gy};
    end
  end

  assign ctl_o   = ctl_q;
  assign div_o   = div_q;
  assign rem_x_o = rem_x_q;
  assign rem_y_o = rem_y_q;
  assign nlo_x_o = nlo_x_q;
  assign nlo_y_o = nlo_y_q;
  assign q_x_o   = q_x_q;
  assign q_y_o   = q_y_q;

endmodule

// ===== rtl/core/segment_intersection_2d_core.sv =====
// Segment pair intersection core: top level with divider chain and output register.
`timescale 1ns / 1ps
// Takes one request per clock while the result is not stalled and returns one
// result per request, in order. The pipeline is the multiply/add front end,
// one divider cell per quotient bit, and the output register. A stalled result
// stops the whole pipeline; no request is lost.
// An endpoint touching the other line counts as a hit; parallel lines miss.
// On a miss the crossing point reads zero; on a hit it is rounded half away
// from zero.
module segment_intersection_2d_core #(
  parameter int unsigned COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  sgi_req_if.sink   req_i,
  sgi_res_if.source res_o
);
  import sgi_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned DW    = 2 * C + 3;
  localparam int unsigned NW    = 3 * C + 3;
  localparam int unsigned DEPTH = C + 7;
  localparam int unsigned CNTW  = $clog2(DEPTH + 1) + 1;

  logic en;

  sgi_ctl_t      ctl_f;
  logic [DW-1:0] div_f;
  logic [NW:0]   num_x_f, num_y_f;

  sgi_ctl_t      ctl_c   [C+1];
  logic [DW-1:0] div_c   [C+1];
  logic [DW-1:0] rem_x_c [C+1];
  logic [DW-1:0] rem_y_c [C+1];
  logic [C-1:0]  nlo_x_c [C+1];
  logic [C-1:0]  nlo_y_c [C+1];
  logic [C-1:0]  q_x_c   [C+1];
  logic [C-1:0]  q_y_c   [C+1];

  logic                out_vld_q, out_hit_q;
  logic signed [C-1:0] out_x_q, out_y_q;
  logic [C-1:0]        res_x, res_y;
  logic [CNTW-1:0]     cnt_q, cnt_d;

  assign en          = !out_vld_q || res_o.ready;
  assign req_i.ready = en;

  sgi_front #(.COORD_BITS(C)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .x1_i    (req_i.seg_a_start_x),
    .y1_i    (req_i.seg_a_start_y),
    .x2_i    (req_i.seg_a_end_x),
    .y2_i    (req_i.seg_a_end_y),
    .x3_i    (req_i.seg_b_start_x),
    .y3_i    (req_i.seg_b_start_y),
    .x4_i    (req_i.seg_b_end_x),
    .y4_i    (req_i.seg_b_end_y),
    .ctl_o   (ctl_f),
    .div_o   (div_f),
    .num_x_o (num_x_f),
    .num_y_o (num_y_f)
  );

  // upper dividend bits seed the remainder; they are below the divisor on a hit
  assign ctl_c[0]   = ctl_f;
  assign div_c[0]   = div_f;
  assign rem_x_c[0] = num_x_f[C+DW-1:C];
  assign rem_y_c[0] = num_y_f[C+DW-1:C];
  assign nlo_x_c[0] = num_x_f[C-1:0];
  assign nlo_y_c[0] = num_y_f[C-1:0];
  assign q_x_c[0]   = '0;
  assign q_y_c[0]   = '0;

  for (genvar i = 0; i < C; i++) begin : g_div
    sgi_div_cell #(.COORD_BITS(C)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctl_i   (ctl_c[i]),
      .div_i   (div_c[i]),
      .rem_x_i (rem_x_c[i]),
      .rem_y_i (rem_y_c[i]),
      .nlo_x_i (nlo_x_c[i]),
      .nlo_y_i (nlo_y_c[i]),
      .q_x_i   (q_x_c[i]),
      .q_y_i   (q_y_c[i]),
      .ctl_o   (ctl_c[i+1]),
      .div_o   (div_c[i+1]),
      .rem_x_o (rem_x_c[i+1]),
      .rem_y_o (rem_y_c[i+1]),
      .nlo_x_o (nlo_x_c[i+1]),
      .nlo_y_o (nlo_y_c[i+1]),
      .q_x_o   (q_x_c[i+1]),
      .q_y_o   (q_y_c[i+1])
    );
  end

  always_comb begin
    res_x = '0;
    res_y = '0;
    if (ctl_c[C].hit) begin
      res_x = ctl_c[C].neg_x ? C'(-q_x_c[C]) : q_x_c[C];
      res_y = ctl_c[C].neg_y ? C'(-q_y_c[C]) : q_y_c[C];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ctl_c[C].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= ctl_c[C].hit;
      out_x_q   <= res_x;
      out_y_q   <= res_y;
    end
  end

  assign res_o.valid   = out_vld_q;
  assign res_o.hit     = out_hit_q;
  assign res_o.cross_x = out_x_q;
  assign res_o.cross_y = out_y_q;

  // requests in flight
  always_comb begin
    cnt_d = cnt_q;
    if (req_i.valid && req_i.ready) cnt_d = cnt_d + 1'b1;
    if (res_o.valid && res_o.ready) cnt_d = cnt_d - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.hit |-> res_o.cross_x == '0 && res_o.cross_y == '0)
    else $error("crossing point nonzero on a miss");

  a_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> cnt_q != '0)
    else $error("result without a pending request");

endmodule
